/* rtl/i2crm_pkg.sv */
// ----------------------------------------------------------------------------
// i2crm_pkg: shared types and constants of the I2C register master
// Holds the transfer structs, state codes, op codes and register indexes.
// ----------------------------------------------------------------------------
package i2crm_pkg;

    localparam int unsigned MAX_BURST_DEF  = 256;
    localparam logic [15:0] PHASE_TICKS_RST = 16'd50;
    localparam logic [15:0] BUS_FREE_RST    = 16'd40;

    localparam logic [0:0] REG_PHASE_TICKS = 1'd0;
    localparam logic [0:0] REG_BUS_FREE    = 1'd1;

    typedef enum logic [2:0] {
        OP_RD_BYTE = 3'd0,
        OP_RD_WORD = 3'd1,
        OP_RD_BURST = 3'd2,
        OP_WR_BYTE = 3'd3,
        OP_WR_WORD = 3'd4,
        OP_UPDATE  = 3'd5
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_START0, ST_START1, ST_START2, ST_WLOW, ST_WHIGH,
        ST_ALOW, ST_AHIGH, ST_RLOW, ST_RHIGH, ST_MLOW, ST_MHIGH,
        ST_STOP0, ST_STOP1, ST_STOP2, ST_GAP
    } state_t;

    typedef struct packed {
        logic        cmd;
        logic [2:0]  op;
        logic [6:0]  device_addr;
        logic [7:0]  reg_addr;
        logic [15:0] write_data;
        logic [8:0]  burst_length;
        logic [2:0]  field_start;
        logic [3:0]  field_length;
        logic        sda_in;
    } in_item_t;

    typedef struct packed {
        logic        scl_level;
        logic        sda_level;
        logic        sda_enable;
        logic        busy_res;
        logic        done_res;
        logic        nack_error;
        logic [15:0] read_result;
        logic        byte_valid;
        logic [7:0]  byte_data;
        logic        last_byte;
    } out_item_t;

    // Patched byte for the read-modify-write.
    function automatic logic [7:0] patch_byte(logic [7:0] orig, logic [7:0] val,
                                              logic [2:0] fs, logic [3:0] fl);
        logic [3:0] len;
        logic [3:0] low;
        logic [8:0] ones;
        logic [7:0] mask;
        len = (fl > ({1'b0, fs} + 4'd1)) ? ({1'b0, fs} + 4'd1) : fl;
        low = {1'b0, fs} + 4'd1 - len;
        ones = (9'd1 << len) - 9'd1;
        mask = ones[7:0] << low;
        return (orig & ~mask) | ((val << low) & mask);
    endfunction

endpackage

/* rtl/i2c_register_master_core.sv */
// ----------------------------------------------------------------------------
// i2c_register_master_core: I2C register master, 7-bit device addressing
// Steps the bus sequencer by one input transfer per clock while not stalled.
// ----------------------------------------------------------------------------
// Results: one result per input transfer, registered in the output stage.
// Throughput: one transfer per cycle while the output stage has space; the
// sequencer state register closes the only loop, with a combinational phase
// counter compare. Reset: asynchronous active low; the sequencer returns to
// idle, registers take phase_ticks 50 and bus_free_phases 40.
module i2c_register_master_core #(
    parameter int unsigned MAX_BURST = i2crm_pkg::MAX_BURST_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  i2crm_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output i2crm_pkg::out_item_t out_data,
    input  logic                 cfg_we,
    input  logic [0:0]           cfg_index,
    input  logic [15:0]          cfg_wdata
);
    localparam int unsigned BW = $clog2(MAX_BURST + 1) > 9 ? $clog2(MAX_BURST + 1) : 9;
    localparam logic [BW-1:0] MAXB = BW'(MAX_BURST);

    logic [15:0] phase_ticks_reg, bus_free_reg;
    i2crm_pkg::state_t state_reg, state_next;
    logic [15:0] phase_reg, phase_next, gap_reg, gap_next;
    logic [3:0]  bit_reg, bit_next;
    logic [7:0]  shift_reg, shift_next, patched_reg, patched_next;
    logic [BW-1:0] bytes_reg, bytes_next;
    logic [15:0] accum_reg, accum_next;
    logic [2:0]  stage_reg, stage_next;
    logic        nack_reg, nack_next, pass_reg, pass_next;
    i2crm_pkg::in_item_t rq_reg, rq_next;
    i2crm_pkg::out_item_t res, ev;
    logic        push, space;

    assign in_ready = space;
    assign push     = in_valid && in_ready;

    i2crm_out_reg u_out (
        .clk, .rst_n, .push, .push_data(res), .space,
        .valid(out_valid), .ready(out_ready), .data(out_data)
    );

    // Configuration writes; indexes beyond the list are dropped by width.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg <= i2crm_pkg::PHASE_TICKS_RST;
            bus_free_reg    <= i2crm_pkg::BUS_FREE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                i2crm_pkg::REG_PHASE_TICKS: phase_ticks_reg <= cfg_wdata;
                i2crm_pkg::REG_BUS_FREE:    bus_free_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Derived request properties.
    logic          rd_path;
    logic [BW-1:0] rx_cnt, bl;
    logic [7:0]    wa;
    logic [16:0]   pc_inc;
    logic [15:0]   pt;
    logic          last_rx;

    always_comb
    begin
        rd_path = (rq_reg.op <= i2crm_pkg::OP_RD_BURST) ||
                  (rq_reg.op == i2crm_pkg::OP_UPDATE && !pass_reg);
        bl = BW'(rq_reg.burst_length);
        if (bl == '0) bl = BW'(1);
        if (bl > MAXB) bl = MAXB;
        if (rq_reg.op == i2crm_pkg::OP_RD_WORD)       rx_cnt = BW'(2);
        else if (rq_reg.op == i2crm_pkg::OP_RD_BURST) rx_cnt = bl;
        else                                          rx_cnt = BW'(1);
        wa = {rq_reg.device_addr, 1'b0};
        pt = (phase_ticks_reg == '0) ? 16'd1 : phase_ticks_reg;
        pc_inc = {1'b0, phase_reg} + 17'd1;
        last_rx = ({1'b0, bytes_reg} + 1'b1) >= {1'b0, rx_cnt};
    end

    // Next state: one step of the sequencer per transfer.
    always_comb
    begin
        logic [2:0] stg;
        logic       go;
        logic [BW-1:0] nb;
        logic [7:0] sh;
        logic [7:0] tx;
        state_next = state_reg; phase_next = phase_reg; gap_next = gap_reg;
        bit_next = bit_reg; shift_next = shift_reg; patched_next = patched_reg;
        bytes_next = bytes_reg; accum_next = accum_reg; stage_next = stage_reg;
        nack_next = nack_reg; pass_next = pass_reg; rq_next = rq_reg;
        ev = '0;
        stg = stage_reg; go = 1'b0; nb = bytes_reg; sh = '0;
        if (in_data.cmd)
        begin
            if (state_reg == i2crm_pkg::ST_IDLE && in_data.op <= i2crm_pkg::OP_UPDATE)
            begin
                rq_next = in_data;
                stage_next = '0; nack_next = 1'b0; pass_next = 1'b0;
                patched_next = '0; bytes_next = '0; accum_next = '0;
                bit_next = '0; shift_next = '0; phase_next = '0;
                state_next = i2crm_pkg::ST_START0;
            end
        end
        else if (state_reg != i2crm_pkg::ST_IDLE)
        begin
            if (pc_inc >= {1'b0, pt})
            begin
                phase_next = '0;
                unique case (state_reg)
                    i2crm_pkg::ST_START0: state_next = i2crm_pkg::ST_START1;
                    i2crm_pkg::ST_START1: state_next = i2crm_pkg::ST_START2;
                    i2crm_pkg::ST_START2:
                    begin
                        stg = stage_reg + 3'd1; go = 1'b1;
                    end
                    i2crm_pkg::ST_WLOW: state_next = i2crm_pkg::ST_WHIGH;
                    i2crm_pkg::ST_WHIGH:
                    begin
                        shift_next = {shift_reg[6:0], 1'b0};
                        bit_next = bit_reg + 4'd1;
                        state_next = (bit_reg + 4'd1 >= 4'd8) ? i2crm_pkg::ST_ALOW
                                                             : i2crm_pkg::ST_WLOW;
                    end
                    i2crm_pkg::ST_ALOW: state_next = i2crm_pkg::ST_AHIGH;
                    i2crm_pkg::ST_AHIGH:
                    begin
                        go = 1'b1;
                        if (in_data.sda_in)
                        begin
                            nack_next = 1'b1;
                            stg = rd_path ? 3'd6 : 3'd4;
                        end
                        else if (!rd_path && stage_reg == 3'd3)
                        begin
                            nb = bytes_reg + 1'b1;
                            bytes_next = nb;
                            if (nb >= ((rq_reg.op == i2crm_pkg::OP_WR_WORD) ? BW'(2) : BW'(1)))
                                stg = stage_reg + 3'd1;
                        end
                        else
                            stg = stage_reg + 3'd1;
                    end
                    i2crm_pkg::ST_RLOW: state_next = i2crm_pkg::ST_RHIGH;
                    i2crm_pkg::ST_RHIGH:
                    begin
                        sh = {shift_reg[6:0], in_data.sda_in};
                        shift_next = sh;
                        bit_next = bit_reg + 4'd1;
                        if (bit_reg + 4'd1 < 4'd8)
                            state_next = i2crm_pkg::ST_RLOW;
                        else
                        begin
                            if (rq_reg.op == i2crm_pkg::OP_RD_WORD && bytes_reg != '0)
                                accum_next = {sh, accum_reg[7:0]};
                            else
                                accum_next = {8'd0, sh};
                            if (rq_reg.op == i2crm_pkg::OP_RD_BURST)
                            begin
                                ev.byte_valid = 1'b1;
                                ev.byte_data = sh;
                                ev.last_byte = last_rx;
                            end
                            state_next = i2crm_pkg::ST_MLOW;
                        end
                    end
                    i2crm_pkg::ST_MLOW: state_next = i2crm_pkg::ST_MHIGH;
                    i2crm_pkg::ST_MHIGH:
                    begin
                        nb = bytes_reg + 1'b1;
                        bytes_next = nb;
                        if (nb >= rx_cnt) stg = stage_reg + 3'd1;
                        go = 1'b1;
                    end
                    i2crm_pkg::ST_STOP0: state_next = i2crm_pkg::ST_STOP1;
                    i2crm_pkg::ST_STOP1: state_next = i2crm_pkg::ST_STOP2;
                    i2crm_pkg::ST_STOP2:
                    begin
                        if (!nack_reg && rq_reg.op == i2crm_pkg::OP_UPDATE && !pass_reg)
                        begin
                            // Write phase of the update follows with no gap.
                            patched_next = i2crm_pkg::patch_byte(accum_reg[7:0],
                                rq_reg.write_data[7:0], rq_reg.field_start,
                                rq_reg.field_length);
                            pass_next = 1'b1;
                            bytes_next = '0;
                            stage_next = '0;
                            state_next = i2crm_pkg::ST_START0;
                        end
                        else
                        begin
                            ev.done_res = 1'b1;
                            ev.nack_error = nack_reg;
                            if (!nack_reg)
                            begin
                                if (rq_reg.op == i2crm_pkg::OP_RD_BYTE ||
                                    rq_reg.op == i2crm_pkg::OP_UPDATE)
                                    ev.read_result = {8'd0, accum_reg[7:0]};
                                else if (rq_reg.op == i2crm_pkg::OP_RD_WORD)
                                    ev.read_result = accum_reg;
                            end
                            if (rq_reg.op >= i2crm_pkg::OP_WR_BYTE && bus_free_reg != '0)
                            begin
                                gap_next = bus_free_reg;
                                state_next = i2crm_pkg::ST_GAP;
                            end
                            else
                                state_next = i2crm_pkg::ST_IDLE;
                        end
                    end
                    i2crm_pkg::ST_GAP:
                    begin
                        if (gap_reg <= 16'd1)
                        begin
                            gap_next = '0;
                            state_next = i2crm_pkg::ST_IDLE;
                        end
                        else
                            gap_next = gap_reg - 16'd1;
                    end
                    default: state_next = i2crm_pkg::ST_IDLE;
                endcase
            end
            else
                phase_next = pc_inc[15:0];
        end
        // Data byte to send, picked with the byte count after this ack.
        if (rq_reg.op == i2crm_pkg::OP_UPDATE)
            tx = patched_reg;
        else if (rq_reg.op == i2crm_pkg::OP_WR_WORD && nb != '0)
            tx = rq_reg.write_data[15:8];
        else
            tx = rq_reg.write_data[7:0];
        // Start the next bus element of the current pass.
        if (go)
        begin
            stage_next = stg;
            if (rd_path)
            begin
                unique case (stg)
                    3'd0, 3'd3: state_next = i2crm_pkg::ST_START0;
                    3'd1: begin shift_next = wa; bit_next = '0;
                                state_next = i2crm_pkg::ST_WLOW; end
                    3'd2: begin shift_next = rq_reg.reg_addr; bit_next = '0;
                                state_next = i2crm_pkg::ST_WLOW; end
                    3'd4: begin shift_next = wa | 8'd1; bit_next = '0;
                                state_next = i2crm_pkg::ST_WLOW; end
                    3'd5: begin shift_next = '0; bit_next = '0;
                                state_next = i2crm_pkg::ST_RLOW; end
                    default: state_next = i2crm_pkg::ST_STOP0;
                endcase
            end
            else
            begin
                unique case (stg)
                    3'd0: state_next = i2crm_pkg::ST_START0;
                    3'd1: begin shift_next = wa; bit_next = '0;
                                state_next = i2crm_pkg::ST_WLOW; end
                    3'd2: begin shift_next = rq_reg.reg_addr; bit_next = '0;
                                state_next = i2crm_pkg::ST_WLOW; end
                    3'd3: begin shift_next = tx; bit_next = '0;
                                state_next = i2crm_pkg::ST_WLOW; end
                    default: state_next = i2crm_pkg::ST_STOP0;
                endcase
            end
        end
    end

    // Line drive for the state after this step.
    logic last_rx_next;
    always_comb
    begin
        logic [BW-1:0] rxn;
        if (rq_next.op == i2crm_pkg::OP_RD_WORD)       rxn = BW'(2);
        else if (rq_next.op == i2crm_pkg::OP_RD_BURST)
        begin
            rxn = BW'(rq_next.burst_length);
            if (rxn == '0) rxn = BW'(1);
            if (rxn > MAXB) rxn = MAXB;
        end
        else rxn = BW'(1);
        last_rx_next = ({1'b0, bytes_next} + 1'b1) >= {1'b0, rxn};
        res = ev;
        res.busy_res = (state_next != i2crm_pkg::ST_IDLE);
        res.scl_level = 1'b1; res.sda_level = 1'b1; res.sda_enable = 1'b0;
        unique case (state_next)
            i2crm_pkg::ST_START0: begin res.scl_level = 1'b0; res.sda_enable = 1'b1; end
            i2crm_pkg::ST_START1: res.sda_enable = 1'b1;
            i2crm_pkg::ST_START2: begin res.sda_level = 1'b0; res.sda_enable = 1'b1; end
            i2crm_pkg::ST_WLOW, i2crm_pkg::ST_WHIGH:
            begin
                res.scl_level = (state_next == i2crm_pkg::ST_WHIGH);
                res.sda_level = shift_next[7]; res.sda_enable = 1'b1;
            end
            i2crm_pkg::ST_ALOW, i2crm_pkg::ST_RLOW: res.scl_level = 1'b0;
            i2crm_pkg::ST_MLOW, i2crm_pkg::ST_MHIGH:
            begin
                res.scl_level = (state_next == i2crm_pkg::ST_MHIGH);
                res.sda_level = last_rx_next; res.sda_enable = 1'b1;
            end
            i2crm_pkg::ST_STOP0:
            begin
                res.scl_level = 1'b0; res.sda_level = 1'b0; res.sda_enable = 1'b1;
            end
            i2crm_pkg::ST_STOP1: begin res.sda_level = 1'b0; res.sda_enable = 1'b1; end
            i2crm_pkg::ST_STOP2: res.sda_enable = 1'b1;
            default: ;
        endcase
    end

    // Advance only on an accepted transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= i2crm_pkg::ST_IDLE;
            phase_reg <= '0; gap_reg <= '0; bit_reg <= '0; shift_reg <= '0;
            patched_reg <= '0; bytes_reg <= '0; accum_reg <= '0;
            stage_reg <= '0; nack_reg <= 1'b0; pass_reg <= 1'b0; rq_reg <= '0;
        end
        else if (push)
        begin
            state_reg <= state_next;
            phase_reg <= phase_next; gap_reg <= gap_next; bit_reg <= bit_next;
            shift_reg <= shift_next; patched_reg <= patched_next;
            bytes_reg <= bytes_next; accum_reg <= accum_next;
            stage_reg <= stage_next; nack_reg <= nack_next; pass_reg <= pass_next;
            rq_reg <= rq_next;
        end
    end
endmodule

/* rtl/i2crm_out_reg.sv */
// ----------------------------------------------------------------------------
// i2crm_out_reg: result register with skid stage
// Decouples the result channel so input can flow while output stalls, until the skid stage is full.
// ----------------------------------------------------------------------------
module i2crm_out_reg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  i2crm_pkg::out_item_t push_data,
    output logic                 space,
    output logic                 valid,
    input  logic                 ready,
    output i2crm_pkg::out_item_t data
);
    logic                 main_vld_reg, skid_vld_reg;
    i2crm_pkg::out_item_t main_reg, skid_reg;

    assign space = !skid_vld_reg;
    assign valid = main_vld_reg;
    assign data  = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_vld_reg <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            if (!main_vld_reg || ready)
            begin
                main_vld_reg <= skid_vld_reg || push;
                skid_vld_reg <= 1'b0;
            end
            else if (push)
            begin
                skid_vld_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!main_vld_reg || ready)
        begin
            main_reg <= skid_vld_reg ? skid_reg : push_data;
        end
        else if (push)
        begin
            skid_reg <= push_data;
        end
    end
endmodule

/* dv/i2c_register_master_core_tb.sv */
// ----------------------------------------------------------------------------
// i2c_register_master_core_tb: self-checking bench for the I2C register master
// Drives requests and bus ticks over valid/ready, predicts every line state
// and result with a local sequencer model, and checks transfers in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2c_register_master_core_tb;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;
    localparam int IN_W           = $bits(i2crm_pkg::in_item_t);

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    i2crm_pkg::in_item_t  in_data;
    logic                 out_valid;
    logic                 out_ready;
    i2crm_pkg::out_item_t out_data;
    logic                 cfg_we;
    logic [0:0]           cfg_index;
    logic [15:0]          cfg_wdata;

    i2c_register_master_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Sequencer model: own copy of the configuration and state
    // ------------------------------------------------------------------
    logic [15:0] cfg_phase_ticks;
    logic [15:0] cfg_bus_free;

    i2crm_pkg::state_t   seq_state;
    logic [15:0]         tick_count;
    logic [3:0]          bit_idx;
    logic [7:0]          shifter;
    logic [8:0]          byte_count;
    logic [15:0]         rx_accum;
    i2crm_pkg::in_item_t held_req;
    logic [15:0]         free_count;
    int                  step_no;
    logic                got_nack;
    logic                write_pass;
    logic [7:0]          field_byte;

    // result flags raised while a phase ends
    logic        r_done;
    logic        r_nack;
    logic [15:0] r_result;
    logic        r_bv;
    logic [7:0]  r_bd;
    logic        r_last;

    i2crm_pkg::out_item_t line_q[$];
    int                   mismatches = 0;

    function automatic bit on_read_path();
        return held_req.op <= i2crm_pkg::OP_RD_BURST ||
               (held_req.op == i2crm_pkg::OP_UPDATE && !write_pass);
    endfunction

    function automatic int bytes_to_receive();
        int n;
        if (held_req.op == i2crm_pkg::OP_RD_WORD)
            return 2;
        if (held_req.op != i2crm_pkg::OP_RD_BURST)
            return 1;
        n = held_req.burst_length;
        if (n == 0)
            n = 1;
        if (n > i2crm_pkg::MAX_BURST_DEF)
            n = i2crm_pkg::MAX_BURST_DEF;
        return n;
    endfunction

    function automatic logic [7:0] data_byte_out();
        if (held_req.op == i2crm_pkg::OP_UPDATE)
            return field_byte;
        if (held_req.op == i2crm_pkg::OP_WR_WORD && byte_count != 0)
            return held_req.write_data[15:8];
        return held_req.write_data[7:0];
    endfunction

    function automatic void load_shifter(logic [7:0] b);
        shifter   = b;
        bit_idx   = 0;
        seq_state = i2crm_pkg::ST_WLOW;
    endfunction

    // Pick the next bus element for the current step of the transaction.
    function automatic void next_element();
        logic [7:0] wr_addr;
        wr_addr = {held_req.device_addr, 1'b0};
        if (on_read_path())
        begin
            case (step_no)
                0, 3: seq_state = i2crm_pkg::ST_START0;
                1: load_shifter(wr_addr);
                2: load_shifter(held_req.reg_addr);
                4: load_shifter(wr_addr | 8'h01);
                5:
                begin
                    shifter   = 0;
                    bit_idx   = 0;
                    seq_state = i2crm_pkg::ST_RLOW;
                end
                default: seq_state = i2crm_pkg::ST_STOP0;
            endcase
        end
        else
        begin
            case (step_no)
                0: seq_state = i2crm_pkg::ST_START0;
                1: load_shifter(wr_addr);
                2: load_shifter(held_req.reg_addr);
                3: load_shifter(data_byte_out());
                default: seq_state = i2crm_pkg::ST_STOP0;
            endcase
        end
    endfunction

    function automatic void close_transaction();
        r_done   = 1'b1;
        r_nack   = got_nack;
        r_result = '0;
        if (!got_nack)
        begin
            if (held_req.op == i2crm_pkg::OP_RD_BYTE || held_req.op == i2crm_pkg::OP_UPDATE)
                r_result = {8'h00, rx_accum[7:0]};
            else if (held_req.op == i2crm_pkg::OP_RD_WORD)
                r_result = rx_accum;
        end
        if (held_req.op >= i2crm_pkg::OP_WR_BYTE && cfg_bus_free != 0)
        begin
            free_count = cfg_bus_free;
            seq_state  = i2crm_pkg::ST_GAP;
        end
        else
            seq_state = i2crm_pkg::ST_IDLE;
    endfunction

    // Merge the field value into the byte read back, clipping the field.
    function automatic void merge_field();
        int         hi;
        int         len;
        int         lo;
        logic [7:0] mask;
        hi  = held_req.field_start;
        len = held_req.field_length;
        if (len > hi + 1)
            len = hi + 1;
        lo   = hi + 1 - len;
        mask = 8'(((1 << len) - 1) << lo);
        field_byte = (rx_accum[7:0] & ~mask) | ((held_req.write_data[7:0] << lo) & mask);
    endfunction

    function automatic void phase_done(logic sda);
        case (seq_state)
            i2crm_pkg::ST_START0: seq_state = i2crm_pkg::ST_START1;
            i2crm_pkg::ST_START1: seq_state = i2crm_pkg::ST_START2;
            i2crm_pkg::ST_START2:
            begin
                step_no++;
                next_element();
            end
            i2crm_pkg::ST_WLOW: seq_state = i2crm_pkg::ST_WHIGH;
            i2crm_pkg::ST_WHIGH:
            begin
                shifter = shifter << 1;
                bit_idx++;
                seq_state = (bit_idx >= 8) ? i2crm_pkg::ST_ALOW : i2crm_pkg::ST_WLOW;
            end
            i2crm_pkg::ST_ALOW: seq_state = i2crm_pkg::ST_AHIGH;
            i2crm_pkg::ST_AHIGH:
            begin
                if (sda)
                begin
                    got_nack = 1'b1;
                    step_no  = on_read_path() ? 6 : 4;
                end
                else if (!on_read_path() && step_no == 3)
                begin
                    byte_count++;
                    if (byte_count >= ((held_req.op == i2crm_pkg::OP_WR_WORD) ? 2 : 1))
                        step_no++;
                end
                else
                    step_no++;
                next_element();
            end
            i2crm_pkg::ST_RLOW: seq_state = i2crm_pkg::ST_RHIGH;
            i2crm_pkg::ST_RHIGH:
            begin
                shifter = {shifter[6:0], sda};
                bit_idx++;
                if (bit_idx < 8)
                    seq_state = i2crm_pkg::ST_RLOW;
                else
                begin
                    if (held_req.op == i2crm_pkg::OP_RD_WORD && byte_count != 0)
                        rx_accum = {shifter, rx_accum[7:0]};
                    else
                        rx_accum = {8'h00, shifter};
                    if (held_req.op == i2crm_pkg::OP_RD_BURST)
                    begin
                        r_bv   = 1'b1;
                        r_bd   = shifter;
                        r_last = (int'(byte_count) + 1 >= bytes_to_receive());
                    end
                    seq_state = i2crm_pkg::ST_MLOW;
                end
            end
            i2crm_pkg::ST_MLOW: seq_state = i2crm_pkg::ST_MHIGH;
            i2crm_pkg::ST_MHIGH:
            begin
                byte_count++;
                if (int'(byte_count) >= bytes_to_receive())
                    step_no++;
                next_element();
            end
            i2crm_pkg::ST_STOP0: seq_state = i2crm_pkg::ST_STOP1;
            i2crm_pkg::ST_STOP1: seq_state = i2crm_pkg::ST_STOP2;
            i2crm_pkg::ST_STOP2:
            begin
                // read part of an update done: patch the byte and write it back
                if (!got_nack && held_req.op == i2crm_pkg::OP_UPDATE && !write_pass)
                begin
                    merge_field();
                    write_pass = 1'b1;
                    step_no    = 0;
                    byte_count = 0;
                    next_element();
                end
                else
                    close_transaction();
            end
            i2crm_pkg::ST_GAP:
            begin
                if (free_count > 0)
                    free_count--;
                if (free_count == 0)
                    seq_state = i2crm_pkg::ST_IDLE;
            end
            default: seq_state = i2crm_pkg::ST_IDLE;
        endcase
    endfunction

    function automatic void model_reset();
        cfg_phase_ticks = i2crm_pkg::PHASE_TICKS_RST;
        cfg_bus_free    = i2crm_pkg::BUS_FREE_RST;
        seq_state  = i2crm_pkg::ST_IDLE;
        tick_count = 0;
        bit_idx    = 0;
        shifter    = 0;
        byte_count = 0;
        rx_accum   = 0;
        held_req   = '0;
        free_count = 0;
        step_no    = 0;
        got_nack   = 0;
        write_pass = 0;
        field_byte = 0;
    endfunction

    // One input transfer in, one line/result transfer out.
    function automatic i2crm_pkg::out_item_t predict_lines(i2crm_pkg::in_item_t it);
        i2crm_pkg::out_item_t o;
        logic [15:0]          ticks;
        r_done = 0; r_nack = 0; r_result = 0; r_bv = 0; r_bd = 0; r_last = 0;
        if (it.cmd)
        begin
            if (seq_state == i2crm_pkg::ST_IDLE && it.op <= i2crm_pkg::OP_UPDATE)
            begin
                held_req   = it;
                step_no    = 0;
                got_nack   = 0;
                write_pass = 0;
                field_byte = 0;
                byte_count = 0;
                rx_accum   = 0;
                bit_idx    = 0;
                shifter    = 0;
                tick_count = 0;
                seq_state  = i2crm_pkg::ST_START0;
            end
        end
        else if (seq_state != i2crm_pkg::ST_IDLE)
        begin
            ticks = (cfg_phase_ticks == 0) ? 16'd1 : cfg_phase_ticks;
            tick_count++;
            if (tick_count >= ticks)
            begin
                tick_count = 0;
                phase_done(it.sda_in);
            end
        end
        o = '0;
        o.scl_level = 1'b1;
        o.sda_level = 1'b1;
        case (seq_state)
            i2crm_pkg::ST_START0: begin o.scl_level = 0; o.sda_enable = 1; end
            i2crm_pkg::ST_START1: o.sda_enable = 1;
            i2crm_pkg::ST_START2: begin o.sda_level = 0; o.sda_enable = 1; end
            i2crm_pkg::ST_WLOW, i2crm_pkg::ST_WHIGH:
            begin
                o.scl_level  = (seq_state == i2crm_pkg::ST_WHIGH);
                o.sda_level  = shifter[7];
                o.sda_enable = 1;
            end
            i2crm_pkg::ST_ALOW, i2crm_pkg::ST_RLOW: o.scl_level = 0;
            i2crm_pkg::ST_MLOW, i2crm_pkg::ST_MHIGH:
            begin
                o.scl_level  = (seq_state == i2crm_pkg::ST_MHIGH);
                o.sda_level  = (int'(byte_count) + 1 >= bytes_to_receive());
                o.sda_enable = 1;
            end
            i2crm_pkg::ST_STOP0:
            begin
                o.scl_level = 0; o.sda_level = 0; o.sda_enable = 1;
            end
            i2crm_pkg::ST_STOP1: begin o.sda_level = 0; o.sda_enable = 1; end
            i2crm_pkg::ST_STOP2: o.sda_enable = 1;
            default: ;
        endcase
        o.busy_res    = (seq_state != i2crm_pkg::ST_IDLE);
        o.done_res    = r_done;
        o.nack_error  = r_nack;
        o.read_result = r_result;
        o.byte_valid  = r_bv;
        o.byte_data   = r_bd;
        o.last_byte   = r_last;
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Gap picker: mostly short, a few long, with stretches of none
    // ------------------------------------------------------------------
    function automatic int pick_gap(ref int calm_left);
        int r;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 999);
        if (r < 5)
            calm_left = $urandom_range(20, 200);
        if (r < 600)
            return 0;
        if (r < 950)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ------------------------------------------------------------------
    // Input side: one transfer per call, predicted on acceptance
    // ------------------------------------------------------------------
    int in_calm = 0;

    task automatic send_item(i2crm_pkg::in_item_t it, bit typed,
                             i2crm_pkg::out_item_t typed_exp);
        int                   gap;
        i2crm_pkg::out_item_t pred;
        gap = pick_gap(in_calm);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = it;
        do @(posedge clk); while (!in_ready);
        pred = predict_lines(it);
        line_q.push_back(typed ? typed_exp : pred);
    endtask

    task automatic send_tick(logic sda);
        i2crm_pkg::in_item_t it;
        it        = '0;
        it.cmd    = 1'b0;
        it.op     = 3'($urandom_range(0, 7));
        it.sda_in = sda;
        send_item(it, 1'b0, '0);
    endtask

    // Advance the bus until the sequencer goes idle. Acknowledge slots get
    // the target's ack unless nack_slot picks one; other samples are random.
    // Now and then drop a request in while busy, which must be ignored.
    task automatic run_to_idle(int nack_slot, bit noisy);
        int                  acks;
        bit                  in_ack;
        i2crm_pkg::in_item_t junk;
        acks = 0;
        while (seq_state != i2crm_pkg::ST_IDLE)
        begin
            if (noisy && $urandom_range(0, 99) < 2)
            begin
                junk     = IN_W'({$urandom, $urandom});
                junk.cmd = 1'b1;
                send_item(junk, 1'b0, '0);
            end
            else
            begin
                in_ack = (seq_state == i2crm_pkg::ST_AHIGH);
                if (in_ack)
                    send_tick((acks + 1 == nack_slot) ? 1'b1 : 1'b0);
                else
                    send_tick(1'($urandom_range(0, 1)));
                if (in_ack && seq_state != i2crm_pkg::ST_AHIGH)
                    acks++;
            end
        end
    endtask

    // Hold the sender until every expected transfer has come back.
    task automatic drain_lines();
        @(negedge clk);
        in_valid = 1'b0;
        while (line_q.size() != 0)
            @(posedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [15:0] val);
        drain_lines();
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(posedge clk);
        if (idx == i2crm_pkg::REG_PHASE_TICKS)
            cfg_phase_ticks = val;
        else
            cfg_bus_free = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Output side: random backpressure and in-order compare
    // ------------------------------------------------------------------
    int out_calm = 0;

    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = pick_gap(out_calm);
            if (stall > 0)
            begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        i2crm_pkg::out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (line_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: unexpected output transfer %h", out_data);
            end
            else
            begin
                want = line_q.pop_front();
                if (out_data.scl_level   !== want.scl_level   ||
                    out_data.sda_level   !== want.sda_level   ||
                    out_data.sda_enable  !== want.sda_enable  ||
                    out_data.busy_res    !== want.busy_res    ||
                    out_data.done_res    !== want.done_res    ||
                    out_data.nack_error  !== want.nack_error  ||
                    out_data.read_result !== want.read_result ||
                    out_data.byte_valid  !== want.byte_valid  ||
                    out_data.byte_data   !== want.byte_data   ||
                    out_data.last_byte   !== want.last_byte)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"ERROR: scl/sda/en/busy/done/nack/res/bv/bd/last ",
                                  "exp %b%b%b%b%b%b %h %b %h %b got %b%b%b%b%b%b %h %b %h %b"},
                                 want.scl_level, want.sda_level, want.sda_enable,
                                 want.busy_res, want.done_res, want.nack_error,
                                 want.read_result, want.byte_valid, want.byte_data,
                                 want.last_byte,
                                 out_data.scl_level, out_data.sda_level, out_data.sda_enable,
                                 out_data.busy_res, out_data.done_res, out_data.nack_error,
                                 out_data.read_result, out_data.byte_valid,
                                 out_data.byte_data, out_data.last_byte);
                end
            end
        end
    end

    // Watchdog: count cycles with no transfer on either channel, no config write and no reset.
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("i2c_register_master_core verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------
    typedef struct {
        i2crm_pkg::in_item_t  req;
        int                   nack_slot;
        bit                   typed;
        i2crm_pkg::out_item_t want;
    } dir_row_t;

    function automatic i2crm_pkg::in_item_t mk_req(logic [2:0] op, logic [6:0] dev,
                                                   logic [7:0] ra, logic [15:0] wd,
                                                   logic [8:0] bl, logic [2:0] fs,
                                                   logic [3:0] fl);
        i2crm_pkg::in_item_t it;
        it = '0;
        it.cmd = 1'b1; it.op = op; it.device_addr = dev; it.reg_addr = ra;
        it.write_data = wd; it.burst_length = bl; it.field_start = fs;
        it.field_length = fl;
        return it;
    endfunction

    function automatic i2crm_pkg::in_item_t rand_req();
        i2crm_pkg::in_item_t it;
        int                  r;
        it     = IN_W'({$urandom, $urandom});
        it.cmd = 1'b1;
        it.op  = 3'($urandom_range(0, 5));
        r = $urandom_range(0, 99);
        // keep bursts short mostly; a few go to the full range
        if (r < 80)
            it.burst_length = 9'($urandom_range(0, 4));
        else if (r < 96)
            it.burst_length = 9'($urandom_range(5, 20));
        return it;
    endfunction

    dir_row_t             rows[$];
    i2crm_pkg::out_item_t idle_lines;
    i2crm_pkg::out_item_t start_lines;

    initial
    begin
        dir_row_t            row;
        i2crm_pkg::in_item_t it;
        int                  pt_list[6];
        int                  bf_list[6];
        int                  n_list[6];
        int                  nack_slot;

        model_reset();
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        cfg_we     = 1'b0;
        cfg_index  = i2crm_pkg::REG_PHASE_TICKS;
        cfg_wdata  = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        idle_lines = '0;
        idle_lines.scl_level = 1'b1;
        idle_lines.sda_level = 1'b1;
        start_lines = '0;
        start_lines.sda_level  = 1'b1;
        start_lines.sda_enable = 1'b1;
        start_lines.busy_res   = 1'b1;

        // tick while idle and unknown ops: no effect, idle lines right after reset
        it = '0;
        row = '{it, 0, 1'b1, idle_lines};                                   rows.push_back(row);
        row = '{mk_req(3'd7, 7'h7f, 8'hff, 16'hffff, 9'h1ff, 3'd7, 4'hf), 0, 1'b1, idle_lines};
        rows.push_back(row);
        row = '{mk_req(3'd6, 7'h00, 8'h00, 16'h0000, 9'h000, 3'd0, 4'h0), 0, 1'b1, idle_lines};
        rows.push_back(row);
        // first request enters the first start phase at once
        row = '{mk_req(i2crm_pkg::OP_RD_BYTE, 7'h00, 8'h00, 16'h0000, 9'd1, 3'd0, 4'd1),
                0, 1'b1, start_lines};
        rows.push_back(row);
        row = '{mk_req(i2crm_pkg::OP_RD_BYTE, 7'h7f, 8'hff, 16'hffff, 9'd1, 3'd7, 4'd8),
                0, 1'b0, '0};
        rows.push_back(row);
        row = '{mk_req(i2crm_pkg::OP_RD_WORD, 7'h55, 8'haa, 16'h0000, 9'd1, 3'd0, 4'd1),
                0, 1'b0, '0};
        rows.push_back(row);
        // burst length zero acts as one, above the maximum it clips
        row = '{mk_req(i2crm_pkg::OP_RD_BURST, 7'h2a, 8'h10, 16'h0000, 9'd0, 3'd0, 4'd1),
                0, 1'b0, '0};
        rows.push_back(row);
        row = '{mk_req(i2crm_pkg::OP_RD_BURST, 7'h2a, 8'h11, 16'h0000, 9'd1, 3'd0, 4'd1),
                0, 1'b0, '0};
        rows.push_back(row);
        row = '{mk_req(i2crm_pkg::OP_RD_BURST, 7'h2a, 8'h12, 16'h0000, 9'd3, 3'd0, 4'd1),
                0, 1'b0, '0};
        rows.push_back(row);
        row = '{mk_req(i2crm_pkg::OP_RD_BURST, 7'h01, 8'h13, 16'h0000, 9'h1ff, 3'd0, 4'd1),
                0, 1'b0, '0};
        rows.push_back(row);
        row = '{mk_req(i2crm_pkg::OP_WR_BYTE, 7'h3c, 8'h20, 16'h0000, 9'd1, 3'd0, 4'd1),
                0, 1'b0, '0};
        rows.push_back(row);
        row = '{mk_req(i2crm_pkg::OP_WR_BYTE, 7'h3c, 8'h21, 16'hffff, 9'd1, 3'd0, 4'd1),
                0, 1'b0, '0};
        rows.push_back(row);
        row = '{mk_req(i2crm_pkg::OP_WR_WORD, 7'h40, 8'h22, 16'h1234, 9'd1, 3'd0, 4'd1),
                0, 1'b0, '0};
        rows.push_back(row);
        // field updates: full byte, one bit, clipped length, zero length
        row = '{mk_req(i2crm_pkg::OP_UPDATE, 7'h11, 8'h30, 16'h00a5, 9'd1, 3'd7, 4'd8),
                0, 1'b0, '0};
        rows.push_back(row);
        row = '{mk_req(i2crm_pkg::OP_UPDATE, 7'h11, 8'h31, 16'h0001, 9'd1, 3'd0, 4'd1),
                0, 1'b0, '0};
        rows.push_back(row);
        row = '{mk_req(i2crm_pkg::OP_UPDATE, 7'h11, 8'h32, 16'h00ff, 9'd1, 3'd3, 4'hf),
                0, 1'b0, '0};
        rows.push_back(row);
        row = '{mk_req(i2crm_pkg::OP_UPDATE, 7'h11, 8'h33, 16'h00ff, 9'd1, 3'd7, 4'd0),
                0, 1'b0, '0};
        rows.push_back(row);
        // target NACKs: address, register, data byte, update read and write parts, burst read address
        row = '{mk_req(i2crm_pkg::OP_RD_BYTE, 7'h12, 8'h40, 16'h0000, 9'd1, 3'd0, 4'd1),
                1, 1'b0, '0};
        rows.push_back(row);
        row = '{mk_req(i2crm_pkg::OP_RD_WORD, 7'h12, 8'h41, 16'h0000, 9'd1, 3'd0, 4'd1),
                2, 1'b0, '0};
        rows.push_back(row);
        row = '{mk_req(i2crm_pkg::OP_WR_WORD, 7'h12, 8'h42, 16'hbeef, 9'd1, 3'd0, 4'd1),
                3, 1'b0, '0};
        rows.push_back(row);
        row = '{mk_req(i2crm_pkg::OP_UPDATE, 7'h12, 8'h43, 16'h000f, 9'd1, 3'd5, 4'd3),
                1, 1'b0, '0};
        rows.push_back(row);
        row = '{mk_req(i2crm_pkg::OP_UPDATE, 7'h12, 8'h44, 16'h000f, 9'd1, 3'd5, 4'd3),
                5, 1'b0, '0};
        rows.push_back(row);
        row = '{mk_req(i2crm_pkg::OP_RD_BURST, 7'h12, 8'h45, 16'h0000, 9'd4, 3'd0, 4'd1),
                3, 1'b0, '0};
        rows.push_back(row);

        // short phases and a small gap keep the directed part quick
        write_reg(i2crm_pkg::REG_PHASE_TICKS, 16'd1);
        write_reg(i2crm_pkg::REG_BUS_FREE, 16'd2);
        foreach (rows[i])
        begin
            send_item(rows[i].req, rows[i].typed, rows[i].want);
            run_to_idle(rows[i].nack_slot, 1'b0);
        end

        // slowest phase setting: only idle ticks, no bus activity
        write_reg(i2crm_pkg::REG_PHASE_TICKS, 16'hffff);
        repeat (20) send_tick(1'($urandom_range(0, 1)));

        // random phases: each one its own setting, extremes included
        pt_list = '{0, 1, 2, 3, 1, 1};
        bf_list = '{0, 3, 1, 40, 65535, 7};
        n_list  = '{8, 10, 6, 5, 1, 10};
        foreach (pt_list[p])
        begin
            write_reg(i2crm_pkg::REG_PHASE_TICKS, 16'(pt_list[p]));
            write_reg(i2crm_pkg::REG_BUS_FREE, 16'(bf_list[p]));
            for (int t = 0; t < n_list[p]; t++)
            begin
                nack_slot = ($urandom_range(0, 99) < 12) ? $urandom_range(1, 5) : 0;
                if ($urandom_range(0, 99) < 5)
                begin
                    // unknown op or tick while idle: ignored
                    it     = IN_W'({$urandom, $urandom});
                    it.op  = 3'($urandom_range(6, 7));
                    send_item(it, 1'b0, '0);
                end
                send_item(rand_req(), 1'b0, '0);
                run_to_idle(nack_slot, 1'b1);
                if (t == 2)
                    drain_lines();
            end
        end

        drain_lines();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && line_q.size() == 0)
            $display("i2c_register_master_core verification clean");
        else
            $display("i2c_register_master_core verification failed");
        $finish;
    end

endmodule
